// ===== rtl/msq_pkg.sv =====
// Shared constants, types and sequencer states for the median-of-three sort block.
// Depends on nothing; the top level, the checker and the testbench import it.
package msq_pkg;

  localparam int ELEMENTS    = 64;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(ELEMENTS);
  localparam int CNT_W       = $clog2(ELEMENTS + 1);
  localparam int STACK_DEPTH = ELEMENTS;
  localparam int RANGE_W     = 2 * IDX_W;

  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_START,
    S_NEXT,
    S_POP_WAIT,
    S_RANGE,
    S_MED,
    S_PR_A,
    S_PR_B,
    S_PR_C,
    S_PR_WA,
    S_PR_WB,
    S_PIV_RD,
    S_PIV_WAIT,
    S_I_INC,
    S_I_RD,
    S_I_CHK,
    S_J_DEC,
    S_J_RD,
    S_J_CHK,
    S_PART,
    S_PUSH_HI,
    S_PUSH_LO,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_e;

endpackage

// ===== rtl/msq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module msq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then registered read; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/median_of_three_quicksort.sv =====
// Median-of-three quicksort block: top level with sequencer, element store and range stack.
// Depends on msq_pkg and msq_ram.

// Values enter one beat per cycle into a 64-entry element store; beats past
// capacity are dropped. A beat with last_i set closes the set: the block
// stalls its input, sorts the store in place in ascending signed order and
// then sends every element out, one beat per element, with final_res_o on the
// largest. The store is a single-port-read RAM, so each element touched costs
// its own read: a compare-and-swap, each scan step of a partition, a stack pop
// and each output beat all wait on a registered read from a RAM.
// The input is taken again as soon as the last element sits in the output
// register.
module median_of_three_quicksort
  import msq_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  value_t value_i,
  input  logic   last_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output value_t sorted_value_o,
  output logic   final_res_o
);

  state_e state_q, state_d, ret_q;
  cnt_t   count_q;
  cnt_t   top_q;
  idx_t   lo_q, hi_q, i_q, j_q, px_q, py_q, k_q;
  logic   swap_only_q;
  logic [1:0] med_q;
  value_t a_q, b_q, pk_q;
  logic   out_valid_q, out_valid_d, final_q;
  value_t out_value_q;

  // RAM ports
  logic                  st_we, st_re;
  idx_t                  st_waddr, st_raddr;
  logic [VALUE_BITS-1:0] st_wdata, st_rdata;
  logic                  sk_we, sk_re;
  idx_t                  sk_waddr, sk_raddr;
  logic [RANGE_W-1:0]    sk_wdata, sk_rdata;

  msq_ram #(.WIDTH(VALUE_BITS), .DEPTH(ELEMENTS)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  msq_ram #(.WIDTH(RANGE_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sk_wdata),
    .re_i    (sk_re),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  // Derived conditions
  value_t rd_val;
  idx_t   mid, hi_m1, n_m1, i_p1;
  logic   in_acc, has_room, out_free, do_swap;
  logic   range_bad, range_pair, i_ok, j_ok, key_lt, key_gt;
  logic   push_hi_ok, push_lo_ok, stack_room, emit_last;
  logic [IDX_W:0] lo_hi_sum;

  assign rd_val     = value_t'(st_rdata);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign has_room   = count_q < cnt_t'(ELEMENTS);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign lo_hi_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = lo_hi_sum[IDX_W:1];
  assign hi_m1      = hi_q - idx_t'(1);
  assign n_m1       = idx_t'(count_q - cnt_t'(1));
  assign i_p1       = i_q + idx_t'(1);
  assign do_swap    = swap_only_q || (a_q > rd_val);
  assign range_bad  = ({1'b0, hi_q} >= (IDX_W+1)'(count_q)) || (lo_q >= hi_q);
  assign range_pair = ({1'b0, hi_q} - {1'b0, lo_q}) < (IDX_W+1)'(2);
  assign i_ok       = ({1'b0, i_q} + (IDX_W+1)'(1)) < {1'b0, hi_q};
  assign j_ok       = j_q > lo_q;
  assign key_lt     = rd_val < pk_q;
  assign key_gt     = rd_val > pk_q;
  assign stack_room = top_q < cnt_t'(STACK_DEPTH);
  assign push_hi_ok = i_ok && stack_room;
  assign push_lo_ok = (({1'b0, lo_q} + (IDX_W+1)'(1)) < {1'b0, i_q}) && stack_room;
  assign emit_last  = ({1'b0, k_q} + (IDX_W+1)'(1)) == (IDX_W+1)'(count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:      if (in_acc && last_i) state_d = S_START;
      S_START:     state_d = (count_q < cnt_t'(2)) ? S_EMIT_RD : S_NEXT;
      S_NEXT:      state_d = (top_q == '0) ? S_EMIT_RD : S_POP_WAIT;
      S_POP_WAIT:  state_d = S_RANGE;
      S_RANGE: begin
        if (range_bad) state_d = S_NEXT;
        else if (range_pair) state_d = S_PR_A;
        else state_d = S_MED;
      end
      S_MED:       state_d = S_PR_A;
      S_PR_A:      state_d = S_PR_B;
      S_PR_B:      state_d = S_PR_C;
      S_PR_C:      state_d = do_swap ? S_PR_WA : ret_q;
      S_PR_WA:     state_d = S_PR_WB;
      S_PR_WB:     state_d = ret_q;
      S_PIV_RD:    state_d = S_PIV_WAIT;
      S_PIV_WAIT:  state_d = S_I_RD;
      S_I_INC:     state_d = S_I_RD;
      S_I_RD:      state_d = i_ok ? S_I_CHK : S_J_DEC;
      S_I_CHK:     state_d = key_lt ? S_I_RD : S_J_DEC;
      S_J_DEC:     state_d = S_J_RD;
      S_J_RD:      state_d = j_ok ? S_J_CHK : S_PART;
      S_J_CHK:     state_d = key_gt ? S_J_DEC : S_PART;
      S_PART:      state_d = S_PR_A;
      S_PUSH_HI:   state_d = S_PUSH_LO;
      S_PUSH_LO:   state_d = S_NEXT;
      S_EMIT_RD:   state_d = S_EMIT_WAIT;
      S_EMIT_WAIT: if (out_free) state_d = emit_last ? S_LOAD : S_EMIT_RD;
      default:     state_d = S_LOAD;
    endcase
  end

  // Memory controls
  always_comb begin
    st_we    = 1'b0;
    st_waddr = px_q;
    st_wdata = b_q;
    st_re    = 1'b0;
    st_raddr = px_q;
    sk_we    = 1'b0;
    sk_waddr = top_q[IDX_W-1:0];
    sk_wdata = {hi_q, i_p1};
    sk_re    = 1'b0;
    sk_raddr = idx_t'(top_q - cnt_t'(1));
    unique case (state_q)
      S_LOAD: begin
        st_we    = in_acc && has_room;
        st_waddr = count_q[IDX_W-1:0];
        st_wdata = value_i;
      end
      S_START: begin
        sk_we    = count_q >= cnt_t'(2);
        sk_waddr = '0;
        sk_wdata = {n_m1, idx_t'(0)};
      end
      S_NEXT:    sk_re = top_q != '0;
      S_PR_A:    st_re = 1'b1;
      S_PR_B: begin
        st_re    = 1'b1;
        st_raddr = py_q;
      end
      S_PR_WA:   st_we = 1'b1;
      S_PR_WB: begin
        st_we    = 1'b1;
        st_waddr = py_q;
        st_wdata = a_q;
      end
      S_PIV_RD: begin
        st_re    = 1'b1;
        st_raddr = hi_m1;
      end
      S_I_RD: begin
        st_re    = i_ok;
        st_raddr = i_q;
      end
      S_J_RD: begin
        st_re    = j_ok;
        st_raddr = j_q;
      end
      S_PUSH_HI: sk_we = push_hi_ok;
      S_PUSH_LO: begin
        sk_we    = push_lo_ok;
        sk_wdata = {i_q - idx_t'(1), lo_q};
      end
      S_EMIT_RD: begin
        st_re    = 1'b1;
        st_raddr = k_q;
      end
      default: ;
    endcase
  end

  // Output valid: load on an emit step, drop once the beat is taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (state_q == S_EMIT_WAIT && out_free) out_valid_d = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        S_LOAD:    if (in_acc && has_room) count_q <= count_q + cnt_t'(1);
        S_START:   top_q <= (count_q >= cnt_t'(2)) ? cnt_t'(1) : '0;
        S_NEXT:    if (top_q != '0) top_q <= top_q - cnt_t'(1);
        S_PUSH_HI: if (push_hi_ok) top_q <= top_q + cnt_t'(1);
        S_PUSH_LO: if (push_lo_ok) top_q <= top_q + cnt_t'(1);
        S_EMIT_WAIT: begin
          if (out_free && emit_last) begin
            count_q <= '0;
            top_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_START: k_q <= '0;
      S_POP_WAIT: ;
      S_RANGE: begin
        {hi_q, lo_q} <= {hi_q, lo_q};
        med_q        <= '0;
        px_q         <= lo_q;
        py_q         <= hi_q;
        swap_only_q  <= 1'b0;
        ret_q        <= S_NEXT;
      end
      S_MED: begin
        med_q       <= med_q + 2'd1;
        swap_only_q <= 1'b0;
        ret_q       <= S_MED;
        case (med_q)
          2'd0: begin
            px_q <= lo_q;
            py_q <= mid;
          end
          2'd1: begin
            px_q <= lo_q;
            py_q <= hi_q;
          end
          2'd2: begin
            px_q <= mid;
            py_q <= hi_q;
          end
          default: begin
            px_q        <= mid;
            py_q        <= hi_m1;
            swap_only_q <= 1'b1;
            ret_q       <= S_PIV_RD;
          end
        endcase
      end
      S_PR_B: a_q <= rd_val;
      S_PR_C: b_q <= rd_val;
      S_PIV_WAIT: begin
        pk_q <= rd_val;
        i_q  <= lo_q + idx_t'(1);
        j_q  <= hi_m1;
      end
      S_I_INC: i_q <= i_p1;
      S_I_CHK: if (key_lt) i_q <= i_p1;
      S_J_DEC: j_q <= j_q - idx_t'(1);
      S_PART: begin
        px_q        <= i_q;
        swap_only_q <= 1'b1;
        if (i_q < j_q) begin
          py_q  <= j_q;
          ret_q <= S_I_INC;
        end else begin
          py_q  <= hi_m1;
          ret_q <= S_PUSH_HI;
        end
      end
      S_EMIT_WAIT: begin
        if (out_free) begin
          out_value_q <= rd_val;
          final_q     <= emit_last;
          k_q         <= k_q + idx_t'(1);
        end
      end
      default: ;
    endcase
    // Latch the popped range
    if (state_q == S_POP_WAIT) begin
      lo_q <= sk_rdata[IDX_W-1:0];
      hi_q <= sk_rdata[RANGE_W-1:IDX_W];
    end
  end

  // Drive the ports; the input is open only while loading
  assign in_stall_o     = state_q != S_LOAD;
  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign final_res_o    = final_q;

endmodule

// ===== rtl/msq_checker.sv =====
// Port-level checker for the median-of-three sort block, bound to the top level.
// Depends on msq_pkg.
module msq_checker
  import msq_pkg::*;
(
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_stall_o,
  input logic   last_i,
  input logic   out_valid_o,
  input logic   out_stall_i,
  input value_t sorted_value_o,
  input logic   final_res_o
);

  logic   have_prev_q;
  value_t prev_q;
  logic   out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  // Track the previous beat of the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else if (out_acc) begin
      have_prev_q <= !final_res_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_acc) prev_q <= sorted_value_o;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sorted_value_o)
      && $stable(final_res_o))
    else $error("stalled output beat changed");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input not stalled after a closing beat");

  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_prev_q |-> sorted_value_o >= prev_q)
    else $error("output run not ascending");

  // The input reopens only together with the final beat of a run
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_stall_o || final_res_o)
    else $error("output beat appeared while input was open");

endmodule

bind median_of_three_quicksort msq_checker u_msq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .last_i         (last_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sorted_value_o (sorted_value_o),
  .final_res_o    (final_res_o)
);

// ===== test/tb.sv =====
// Testbench for median_of_three_quicksort: loads sets of values, checks sorted output beats.
// Depends on msq_pkg and the block's RTL; expected beats come from a local sorting predictor.
module tb;
  import msq_pkg::*;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  value_t value_i = '0;
  logic   last_i = 1'b0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  value_t sorted_value_o;
  logic   final_res_o;

  typedef struct {
    value_t val;
    logic   fin;
  } sorted_beat_t;

  typedef struct {
    value_t val;
    logic   lst;
    bit     typed;
    value_t exp_val;
  } stim_row_t;

  sorted_beat_t sorted_q[$];
  value_t       set_store[$];
  int           err_cnt = 0;
  int           cycle_cnt = 0;
  int           send_pct = 0;
  int           stall_pct = 0;
  int           hold_left = 0;

  median_of_three_quicksort dut (.*);

  // Clock: period 20
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort on runaway
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 1000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive receiver stall: long hold-off first, else random
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left   = hold_left - 1;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Check every output beat against the oldest expectation
  always @(posedge clk_i) begin
    sorted_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_q.size() == 0) begin
        $error("unexpected beat: sorted_value %0d final_res %0b", sorted_value_o, final_res_o);
        err_cnt++;
      end else begin
        want = sorted_q.pop_front();
        if (sorted_value_o !== want.val) begin
          $error("sorted_value: expected %0d, got %0d", want.val, sorted_value_o);
          err_cnt++;
        end
        if (final_res_o !== want.fin) begin
          $error("final_res: expected %0b, got %0b", want.fin, final_res_o);
          err_cnt++;
        end
      end
    end
  end

  // Store a value if room; on last, sort the set ascending and queue its beats
  function automatic void predict_sort(value_t v, logic lst, bit typed, value_t exp_val);
    value_t       arr[$];
    value_t       t;
    sorted_beat_t b;
    int           k;
    if (set_store.size() < ELEMENTS) set_store.push_back(v);
    if (!lst) return;
    arr = set_store;
    for (int i = 1; i < arr.size(); i++) begin
      t = arr[i];
      k = i - 1;
      while (k >= 0 && arr[k] > t) begin
        arr[k+1] = arr[k];
        k--;
      end
      arr[k+1] = t;
    end
    for (int i = 0; i < arr.size(); i++) begin
      b.val = (typed && arr.size() == 1) ? exp_val : arr[i];
      b.fin = (i == arr.size() - 1);
      sorted_q.push_back(b);
    end
    set_store.delete();
  endfunction

  // Offer one beat after a random gap, hold it until taken
  task automatic send_beat(value_t v, logic lst, bit typed = 0, value_t exp_val = '0);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    value_i    = v;
    last_i     = lst;
    do @(posedge clk_i); while (in_stall_o);
    predict_sort(v, lst, typed, exp_val);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return value_t'($signed($urandom_range(0, 6)) - 3);
      default: return value_t'($urandom);
    endcase
  endfunction

  // One random set; length mostly short, a few at or past capacity
  task automatic send_set();
    int len;
    case ($urandom_range(0, 19))
      0:       len = $urandom_range(64, 70);
      1, 2:    len = $urandom_range(13, 40);
      default: len = $urandom_range(1, 12);
    endcase
    for (int i = 0; i < len; i++) send_beat(pick_value(), i == len - 1);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sorted_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  stim_row_t dir_tab[] = '{
    '{32'sh7fffffff, 1'b1, 1, 32'sh7fffffff},
    '{32'sh80000000, 1'b1, 1, 32'sh80000000},
    '{32'sh00000000, 1'b1, 1, 32'sh00000000},
    '{32'shffffffff, 1'b1, 1, 32'shffffffff},
    '{32'sh7fffffff, 1'b0, 0, '0},
    '{32'sh80000000, 1'b1, 0, '0},
    '{32'sh00000005, 1'b0, 0, '0},
    '{32'sh00000005, 1'b0, 0, '0},
    '{32'sh00000005, 1'b1, 0, '0},
    '{32'sh00000003, 1'b0, 0, '0},
    '{32'sh00000001, 1'b0, 0, '0},
    '{32'sh00000002, 1'b1, 0, '0},
    '{32'shfffffffe, 1'b0, 0, '0},
    '{32'sh00000009, 1'b0, 0, '0},
    '{32'sh80000000, 1'b0, 0, '0},
    '{32'sh7fffffff, 1'b0, 0, '0},
    '{32'sh00000000, 1'b0, 0, '0},
    '{32'shffffffff, 1'b1, 0, '0}
  };

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows, no idling
    foreach (dir_tab[r])
      send_beat(dir_tab[r].val, dir_tab[r].lst, dir_tab[r].typed, dir_tab[r].exp_val);
    drain();

    // Overfill the store: values past capacity drop, last still sorts
    for (int i = 0; i < 66; i++) send_beat(value_t'($urandom), i == 65);
    drain();

    // Hold off the receiver while sets keep coming in
    hold_left = 400;
    send_set();
    send_set();
    send_set();
    drain();

    // Random sets across idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_pct  = (ph == 1) ? 46 : (ph == 3) ? 17 : 0;
      stall_pct = (ph == 2) ? 46 : (ph == 3) ? 17 : 0;
      repeat (5) send_set();
      drain();
    end

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
